// File: src/gmdps_pkg.sv
// Shared types and constants for the greedy minimum-distance point selector.
// No dependencies.
`default_nettype none

package gmdps_pkg;

  localparam int COORD_WIDTH  = 16;
  localparam int NUM_AXES     = 3;
  localparam int IDX_WIDTH    = 20;
  localparam int SEP_WIDTH    = 16;
  localparam int DIMS_WIDTH   = 2;
  localparam int CAPACITY_DEF = 1024;
  localparam int MAX_DIMS_DEF = 3;
  localparam int QUEUE_DEPTH  = 2;
  localparam int PADDR_WIDTH  = 3;
  localparam int PDATA_WIDTH  = 32;

  localparam logic [IDX_WIDTH-1:0] IDX_MAX = '1;

  // Register indexes (byte address = 4 * index)
  typedef enum logic [0:0] {
    REG_MIN_SEP   = 1'b0,
    REG_DIMS_USED = 1'b1
  } gmdps_reg_t;

  typedef struct packed {
    logic [SEP_WIDTH-1:0]  min_sep;
    logic [DIMS_WIDTH-1:0] dims;
  } gmdps_cfg_t;

  // One queued word: start flag, arrival index, coordinates (x lowest)
  typedef struct packed {
    logic                                start;
    logic [IDX_WIDTH-1:0]                idx;
    logic [NUM_AXES-1:0][COORD_WIDTH-1:0] coord;
  } gmdps_item_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_EMIT
  } gmdps_state_t;

endpackage

`default_nettype wire

// File: src/gmdps_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module gmdps_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 1024,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// File: src/gmdps_front.sv
// Front end: takes input words, assigns arrival indexes, queues them.
// Depends on gmdps_pkg.
`default_nettype none

module gmdps_front (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              start_of_set,
  input  logic [gmdps_pkg::COORD_WIDTH-1:0] coord_x,
  input  logic [gmdps_pkg::COORD_WIDTH-1:0] coord_y,
  input  logic [gmdps_pkg::COORD_WIDTH-1:0] coord_z,
  output logic                              q_valid,
  input  logic                              q_ready,
  output gmdps_pkg::gmdps_item_t            q_item
);
  import gmdps_pkg::*;

  localparam int PW = $clog2(QUEUE_DEPTH);
  localparam int FW = $clog2(QUEUE_DEPTH + 1);

  gmdps_item_t          slot [QUEUE_DEPTH];
  logic [PW-1:0]        wr_ptr;
  logic [PW-1:0]        rd_ptr;
  logic [FW-1:0]        fill;
  logic [IDX_WIDTH-1:0] counter;
  logic [IDX_WIDTH-1:0] idx_now;
  logic [IDX_WIDTH-1:0] counter_next;
  logic                 push;
  logic                 pop;

  assign in_ready = (fill != FW'(QUEUE_DEPTH));
  assign q_valid  = (fill != '0);
  assign q_item   = slot[rd_ptr];
  assign push     = in_valid && in_ready;
  assign pop      = q_valid && q_ready;

  // start of set restarts the index; counter saturates
  assign idx_now      = start_of_set ? '0 : counter;
  assign counter_next = (idx_now == IDX_MAX) ? idx_now : idx_now + 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr  <= '0;
      rd_ptr  <= '0;
      fill    <= '0;
      counter <= '0;
    end else begin
      if (push) begin
        wr_ptr  <= wr_ptr + 1'b1;
        counter <= counter_next;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        fill <= fill + 1'b1;
      end else if (pop && !push) begin
        fill <= fill - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr].start <= start_of_set;
      slot[wr_ptr].idx   <= idx_now;
      slot[wr_ptr].coord <= {coord_z, coord_y, coord_x};
    end
  end

endmodule

`default_nettype wire

// File: src/gmdps_back.sv
// Back end: scans the accepted-point store, decides, stores and emits.
// Depends on gmdps_pkg and gmdps_ram.
`default_nettype none

module gmdps_back #(
  parameter int CAPACITY = gmdps_pkg::CAPACITY_DEF,
  parameter int MAX_DIMS = gmdps_pkg::MAX_DIMS_DEF
) (
  input  logic                                     clk,
  input  logic                                     rst,
  input  gmdps_pkg::gmdps_cfg_t                    cfg,
  input  logic                                     q_valid,
  output logic                                     q_ready,
  input  gmdps_pkg::gmdps_item_t                   q_item,
  output logic                                     out_valid,
  input  logic                                     out_ready,
  output logic [gmdps_pkg::IDX_WIDTH-1:0]          point_index,
  output logic signed [gmdps_pkg::COORD_WIDTH-1:0] out_x,
  output logic signed [gmdps_pkg::COORD_WIDTH-1:0] out_y,
  output logic signed [gmdps_pkg::COORD_WIDTH-1:0] out_z,
  output logic                                     store_full
);
  import gmdps_pkg::*;

  localparam int CW  = $clog2(CAPACITY + 1);
  localparam int AW  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int DW  = MAX_DIMS * COORD_WIDTH;
  localparam int XW  = COORD_WIDTH + 2;

  gmdps_state_t state;
  gmdps_state_t state_next;
  gmdps_item_t  pt;
  logic [CW-1:0] cnt;
  logic [CW-1:0] cnt_eff;
  logic [CW-1:0] issue_ptr;
  logic          rd_pending;
  logic          issue;
  logic          hit;
  logic          full;
  logic          load_out;
  logic          ram_we;
  logic [DW-1:0] ram_wdata;
  logic [DW-1:0] ram_rdata;
  logic [DIMS_WIDTH-1:0] nd;
  logic [MAX_DIMS-1:0]   near;
  logic signed [XW-1:0]  sep_ext;

  assign cnt_eff = q_item.start ? '0 : cnt;
  assign full    = (cnt == CW'(CAPACITY));

  // effective axis count: zero means one, clamp at MAX_DIMS
  always_comb begin
    if (cfg.dims == '0) begin
      nd = DIMS_WIDTH'(1);
    end else if (cfg.dims > DIMS_WIDTH'(MAX_DIMS)) begin
      nd = DIMS_WIDTH'(MAX_DIMS);
    end else begin
      nd = cfg.dims;
    end
  end

  assign sep_ext = $signed(XW'(cfg.min_sep));

  // |p - s| <= sep on an axis iff both signed differences are <= sep
  for (genvar a = 0; a < MAX_DIMS; a++) begin : g_axis
    logic signed [XW-1:0] p_ext;
    logic signed [XW-1:0] s_ext;
    logic signed [XW-1:0] d_pos;
    logic signed [XW-1:0] d_neg;
    assign p_ext = XW'($signed(pt.coord[a]));
    assign s_ext = XW'($signed(ram_rdata[a*COORD_WIDTH +: COORD_WIDTH]));
    assign d_pos = p_ext - s_ext;
    assign d_neg = s_ext - p_ext;
    assign near[a] = ((d_pos <= sep_ext) && (d_neg <= sep_ext))
                     || !(DIMS_WIDTH'(a) < nd);
    assign ram_wdata[a*COORD_WIDTH +: COORD_WIDTH] = pt.coord[a];
  end

  assign hit = rd_pending && (&near);

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (q_valid) begin
          state_next = (cnt_eff == '0) ? ST_EMIT : ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (hit) begin
          state_next = ST_IDLE;
        end else if (issue_ptr == cnt) begin
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (!out_valid || out_ready) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    q_ready  = 1'b0;
    issue    = 1'b0;
    load_out = 1'b0;
    case (state)
      ST_IDLE: q_ready  = 1'b1;
      ST_SCAN: issue    = (issue_ptr != cnt) && !hit;
      ST_EMIT: load_out = !out_valid || out_ready;
      default: ;
    endcase
  end

  assign ram_we = load_out && !full;

  gmdps_ram #(
    .WIDTH (DW),
    .DEPTH (CAPACITY)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (cnt[AW-1:0]),
    .wdata (ram_wdata),
    .re    (issue),
    .raddr (issue_ptr[AW-1:0]),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      cnt        <= '0;
      issue_ptr  <= '0;
      rd_pending <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      state <= state_next;
      if (q_ready && q_valid) begin
        cnt        <= cnt_eff;
        issue_ptr  <= '0;
        rd_pending <= 1'b0;
      end else begin
        rd_pending <= issue;
        if (issue) begin
          issue_ptr <= issue_ptr + 1'b1;
        end
      end
      if (ram_we) begin
        cnt <= cnt + 1'b1;
      end
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_ready && q_valid) begin
      pt <= q_item;
    end
    if (load_out) begin
      point_index <= pt.idx;
      out_x       <= pt.coord[0];
      out_y       <= pt.coord[1];
      out_z       <= pt.coord[2];
      store_full  <= full;
    end
  end

endmodule

`default_nettype wire

// File: src/greedy_min_distance_point_select.sv
// Top level of the greedy minimum-distance point selector: APB registers,
// front end, back end. Depends on gmdps_pkg, gmdps_front, gmdps_back.
`default_nettype none

// Points arrive one word at a time on the in channel; a point is kept and
// sent out on the out channel when its Chebyshev distance (largest per-axis
// absolute difference over the first dims_used axes) to every point kept so
// far in the set is greater than min_separation. start_of_set empties the
// store and restarts point_index at zero before that point is checked.
// point_index counts every arriving point, kept or not, and sticks at its
// maximum. Once CAPACITY points are stored, a qualifying point is still sent
// out, with store_full set, but not stored. The back end checks a point
// against each of the N stored points in turn, since the store is a
// single-read-port RAM walked one entry per cycle. A two-word queue in
// front and an output register behind let input and output stall
// independently of the scan.
// No clearing pass after reset: the store is tracked by its fill count.
// Configuration writes belong only to idle periods.
module greedy_min_distance_point_select #(
  parameter int CAPACITY = gmdps_pkg::CAPACITY_DEF,
  parameter int MAX_DIMS = gmdps_pkg::MAX_DIMS_DEF
) (
  input  logic                                     clk,
  input  logic                                     rst,
  // APB configuration port
  input  logic                                     psel,
  input  logic                                     penable,
  input  logic                                     pwrite,
  input  logic [gmdps_pkg::PADDR_WIDTH-1:0]        paddr,
  input  logic [gmdps_pkg::PDATA_WIDTH-1:0]        pwdata,
  output logic [gmdps_pkg::PDATA_WIDTH-1:0]        prdata,
  output logic                                     pready,
  // input words
  input  logic                                     in_valid,
  output logic                                     in_ready,
  input  logic                                     start_of_set,
  input  logic signed [gmdps_pkg::COORD_WIDTH-1:0] coord_x,
  input  logic signed [gmdps_pkg::COORD_WIDTH-1:0] coord_y,
  input  logic signed [gmdps_pkg::COORD_WIDTH-1:0] coord_z,
  // result words
  output logic                                     out_valid,
  input  logic                                     out_ready,
  output logic [gmdps_pkg::IDX_WIDTH-1:0]          point_index,
  output logic signed [gmdps_pkg::COORD_WIDTH-1:0] out_x,
  output logic signed [gmdps_pkg::COORD_WIDTH-1:0] out_y,
  output logic signed [gmdps_pkg::COORD_WIDTH-1:0] out_z,
  output logic                                     store_full
);
  import gmdps_pkg::*;

  gmdps_cfg_t  cfg;
  gmdps_item_t q_item;
  gmdps_reg_t  reg_sel;
  logic        q_valid;
  logic        q_ready;
  logic        cfg_wr;

  // Registers sit at 4 * index; only paddr[2] is decoded.
  assign pready  = 1'b1;
  assign reg_sel = gmdps_reg_t'(paddr[2]);
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.min_sep <= '0;
      cfg.dims    <= DIMS_WIDTH'(3);
    end else if (cfg_wr) begin
      case (reg_sel)
        REG_MIN_SEP:   cfg.min_sep <= pwdata[SEP_WIDTH-1:0];
        REG_DIMS_USED: cfg.dims    <= pwdata[DIMS_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_MIN_SEP:   prdata = PDATA_WIDTH'(cfg.min_sep);
      REG_DIMS_USED: prdata = PDATA_WIDTH'(cfg.dims);
      default:       prdata = '0;
    endcase
  end

  // front: accept, index, queue
  gmdps_front u_front (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .start_of_set (start_of_set),
    .coord_x      (coord_x),
    .coord_y      (coord_y),
    .coord_z      (coord_z),
    .q_valid      (q_valid),
    .q_ready      (q_ready),
    .q_item       (q_item)
  );

  // back: store scan, decision, output register
  gmdps_back #(
    .CAPACITY (CAPACITY),
    .MAX_DIMS (MAX_DIMS)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .q_valid     (q_valid),
    .q_ready     (q_ready),
    .q_item      (q_item),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .point_index (point_index),
    .out_x       (out_x),
    .out_y       (out_y),
    .out_z       (out_z),
    .store_full  (store_full)
  );

  // An accepted word is in the queue on the next cycle.
  a_push_visible: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> q_valid)
    else $error("accepted word missing from queue");

  // Queue full implies there is something for the back end.
  a_full_has_data: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> q_valid)
    else $error("input stalled with empty queue");

  // A full store needs at least CAPACITY earlier arrivals in the set.
  a_full_index: assert property (@(posedge clk) disable iff (rst)
    (out_valid && store_full) |-> (point_index >= IDX_WIDTH'(CAPACITY)))
    else $error("store_full with too small point_index");

  // Reset drops any pending result.
  a_reset_out: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid after reset");

endmodule

`default_nettype wire
